// ----- rtl/tsm_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tsm_pkg
// Shared types and constants for the three-stack shared-memory block.
// ============================================================================
package tsm_pkg;

  localparam int MAX_DEPTH  = 16;
  localparam int NUM_STACKS = 3;

  localparam int VAL_W  = 32;
  localparam int CMD_W  = 2;
  localparam int SEL_W  = 2;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 5;

  localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int MEM_DEPTH = NUM_STACKS * MAX_DEPTH;
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // APB register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_CAPACITY = 1'b0;

  // commands
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TOP  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [SEL_W-1:0]        stack_select;
    logic signed [VAL_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] top_value;
    logic [STAT_W-1:0]       status;
    logic                    stack_empty;
    logic                    stack_full;
  } out_item_t;

  // result fields known at issue; top value comes from RAM when use_ram is set
  typedef struct packed {
    logic                    use_ram;
    logic signed [VAL_W-1:0] top_imm;
    logic [STAT_W-1:0]       status;
    logic                    stack_empty;
    logic                    stack_full;
  } rsp_info_t;

endpackage

// ----- rtl/tsm_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tsm_ram
// Generic single-port synchronous RAM with registered read data.
// ============================================================================
module tsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                           wdata,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tsm_stack_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tsm_stack_ctrl
// Fill counts per stack, command decode, and RAM access for one item.
// ============================================================================
module tsm_stack_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  tsm_pkg::in_item_t             item,
  input  logic [tsm_pkg::CAP_W-1:0]     cap_cfg,
  output logic                          ram_wr_en,
  output logic                          ram_rd_en,
  output logic [tsm_pkg::ADDR_W-1:0]    ram_addr,
  output logic [tsm_pkg::VAL_W-1:0]     ram_wdata,
  output tsm_pkg::rsp_info_t            info
);
  import tsm_pkg::*;

  logic [CNT_W-1:0] counts_r   [NUM_STACKS];
  logic [CNT_W-1:0] counts_nxt [NUM_STACKS];

  logic [CMP_W-1:0] cap_ext;
  logic [CNT_W-1:0] cap_eff;
  logic             sel_ok;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_new;
  logic [CNT_W-1:0] top_pos;
  logic             push_ok;
  logic [STAT_W-1:0] status;
  logic             new_empty;
  logic             new_full;

  // clamp the register to 1..MAX_DEPTH
  always_comb begin
    cap_ext = CMP_W'(cap_cfg);
    if (cap_ext == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_ext > CMP_W'(MAX_DEPTH)) begin
      cap_eff = CNT_W'(MAX_DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_ext);
    end
  end

  always_comb begin
    sel_ok = (item.stack_select < SEL_W'(NUM_STACKS));
    cnt = '0;
    for (int s = 0; s < NUM_STACKS; s++) begin
      if (item.stack_select == SEL_W'(s)) begin
        cnt = counts_r[s];
      end
    end

    cnt_new = cnt;
    status  = ST_DONE;
    push_ok = 1'b0;
    case (item.command)
      CMD_PUSH: begin
        if (cnt >= cap_eff) begin
          status = ST_FULL;
        end else begin
          push_ok = 1'b1;
          cnt_new = cnt + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (cnt == '0) begin
          status = ST_EMPTY;
        end else begin
          cnt_new = cnt - CNT_W'(1);
        end
      end
      CMD_TOP: begin
        if (cnt == '0) begin
          status = ST_EMPTY;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase

    new_empty = (cnt_new == '0);
    new_full  = (cnt_new >= cap_eff);
    top_pos   = cnt_new - CNT_W'(1);
  end

  // push writes the new top; every other item on a valid stack whose new fill is non-zero reads the new top
  assign ram_addr  = ADDR_W'(item.stack_select) * ADDR_W'(MAX_DEPTH)
                     + ADDR_W'(top_pos[IDX_W-1:0]);
  assign ram_wdata = item.push_value;
  assign ram_wr_en = accept && sel_ok && push_ok;
  assign ram_rd_en = accept && sel_ok && !push_ok && !new_empty;

  always_comb begin
    info.use_ram     = sel_ok && !push_ok && !new_empty;
    info.top_imm     = (sel_ok && push_ok) ? item.push_value : '0;
    info.status      = sel_ok ? status : ST_DONE;
    info.stack_empty = sel_ok ? new_empty : 1'b1;
    info.stack_full  = sel_ok ? new_full : 1'b0;
  end

  always_comb begin
    for (int s = 0; s < NUM_STACKS; s++) begin
      counts_nxt[s] = counts_r[s];
      if (accept && sel_ok && (item.stack_select == SEL_W'(s))) begin
        counts_nxt[s] = cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_STACKS; s++) begin
        counts_r[s] <= '0;
      end
    end else begin
      for (int s = 0; s < NUM_STACKS; s++) begin
        counts_r[s] <= counts_nxt[s];
      end
    end
  end

endmodule

// ----- rtl/three_stacks_in_one_memory.sv -----
`timescale 1ns / 1ps
// ============================================================================
// three_stacks_in_one_memory
// Three stacks in fixed regions of one shared entry RAM, APB capacity register.
// ============================================================================
// Pipeline: an input transfer registers the RAM read and the stage-1 info,
//   then the output register holds the result.
// Throughput: one item per cycle while the result side does not stall; counts update at the transfer edge, so
//   the next item sees them at once and the RAM port is used once per item.
// Reset: synchronous, active low; clears fill counts and valid flags and
//   sets the capacity to 16. The entry RAM is not cleared.
module three_stacks_in_one_memory (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tsm_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tsm_pkg::out_item_t              out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tsm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tsm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tsm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import tsm_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] cap_nxt;
  logic             cfg_wr;
  logic             cfg_hit;

  logic             accept;
  logic             ram_wr_en;
  logic             ram_rd_en;
  logic [ADDR_W-1:0] ram_addr;
  logic [VAL_W-1:0] ram_wdata;
  logic [VAL_W-1:0] ram_rdata;
  rsp_info_t        info;

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  rsp_info_t        s1_info_r;
  logic             s1_move;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_data_r;
  out_item_t        s1_result;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == CFG_IDX_CAPACITY);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_hit;
  assign cap_nxt    = cfg_wr ? cfg_pwdata[CAP_W-1:0] : cap_r;
  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // RAM data is held until the next read, which only comes with a transfer
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign accept   = in_valid && in_ready;

  tsm_stack_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .cap_cfg   (cap_r),
    .ram_wr_en (ram_wr_en),
    .ram_rd_en (ram_rd_en),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .info      (info)
  );

  tsm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MEM_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .wr_en (ram_wr_en),
    .rd_en (ram_rd_en),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_result.top_value   = s1_info_r.use_ram ? ram_rdata : s1_info_r.top_imm;
    s1_result.status      = s1_info_r.status;
    s1_result.stack_empty = s1_info_r.stack_empty;
    s1_result.stack_full  = s1_info_r.stack_full;
  end

  assign s1_valid_nxt  = accept || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info;
    end
    if (s1_move) begin
      out_data_r <= s1_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sim/three_stacks_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// three_stacks_checker
// Tracks the capacity register and the three stacks from the observed
// transfers, predicts every result and compares it field by field.
// ============================================================================
module three_stacks_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  tsm_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  tsm_pkg::out_item_t             out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic                           cfg_pready,
  input  logic [tsm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tsm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output int                             fail_count,
  output int                             pending_count
);
  import tsm_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] CAP_ADDR = CFG_ADDR_W'(4 * int'(CFG_IDX_CAPACITY));

  logic signed [VAL_W-1:0] stack_mem [NUM_STACKS][MAX_DEPTH];
  int                      stack_depth [NUM_STACKS];
  logic [CAP_W-1:0]        capacity_reg;
  out_item_t               expected_replies [$];
  int                      failures;

  // out-of-range register values clamp into 1..MAX_DEPTH
  function automatic int effective_capacity();
    if (capacity_reg == '0) return 1;
    if (int'(capacity_reg) > MAX_DEPTH) return MAX_DEPTH;
    return int'(capacity_reg);
  endfunction

  // carry out one command on the tracked stacks and return its result
  function automatic out_item_t apply_stack_op(in_item_t item);
    out_item_t res;
    int        sel;
    int        cap;
    int        cnt;
    res = '0;
    sel = int'(item.stack_select);
    cap = effective_capacity();
    if (sel >= NUM_STACKS) begin
      res.status      = ST_DONE;
      res.stack_empty = 1'b1;
      return res;
    end
    res.status = ST_DONE;
    cnt = stack_depth[sel];
    case (item.command) inside
      CMD_PUSH: begin
        if (cnt >= cap) begin
          res.status = ST_FULL;
        end else begin
          stack_mem[sel][cnt] = item.push_value;
          cnt++;
        end
      end
      CMD_POP, CMD_TOP: begin
        if (cnt == 0) res.status = ST_EMPTY;
        else if (item.command == CMD_POP) cnt--;
      end
      default: ;
    endcase
    stack_depth[sel] = cnt;
    res.stack_empty = (cnt == 0);
    res.stack_full  = (cnt >= cap);
    if (cnt != 0) res.top_value = stack_mem[sel][cnt-1];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (stack_depth[i]) stack_depth[i] = 0;
      capacity_reg = CAP_RESET;
      expected_replies.delete();
      failures = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == CAP_ADDR)
        capacity_reg = cfg_pwdata[CAP_W-1:0];

      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          if (failures < 10)
            $display("%0t: unexpected result top=%0d st=%0d empty=%0b full=%0b",
                     $realtime, out_data.top_value, out_data.status,
                     out_data.stack_empty, out_data.stack_full);
          failures++;
        end else begin
          want = expected_replies.pop_front();
          if (out_data.top_value !== want.top_value || out_data.status !== want.status ||
              out_data.stack_empty !== want.stack_empty ||
              out_data.stack_full !== want.stack_full) begin
            if (failures < 10)
              $display("%0t: exp top=%0d st=%0d e=%0b f=%0b, got top=%0d st=%0d e=%0b f=%0b",
                       $realtime, want.top_value, want.status, want.stack_empty,
                       want.stack_full, out_data.top_value, out_data.status,
                       out_data.stack_empty, out_data.stack_full);
            failures++;
          end
        end
      end

      if (in_valid && in_ready) expected_replies.push_back(apply_stack_op(in_data));
    end
    fail_count    <= failures;
    pending_count <= expected_replies.size();
  end

endmodule

// ----- sim/three_stacks_in_one_memory_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// three_stacks_in_one_memory_test
// Drives pushes, pops and top reads through several capacity settings and
// traffic patterns; the checker beside the block predicts and compares.
// ============================================================================
module three_stacks_in_one_memory_test;
  import tsm_pkg::*;

  localparam logic [CMD_W-1:0]      CMD_NONE     = 2'd3;  // no operation
  localparam logic [SEL_W-1:0]      SEL_NONE     = SEL_W'(NUM_STACKS);
  localparam logic [CFG_ADDR_W-1:0] CAP_ADDR     = CFG_ADDR_W'(4 * int'(CFG_IDX_CAPACITY));
  localparam int                    IDLE_LIMIT   = 4000;
  localparam int                    SETTLE_CYCLES = 8;
  localparam int                    HOLD_CYCLES  = 300;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  in_item_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int pending_count;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_request  = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int cap_plan [9]  = '{16, 1, 3, 31, 0, 8, 17, 5, 16};

  always #5 clk = ~clk;

  three_stacks_in_one_memory u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  three_stacks_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
                           input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{cmd, sel, val};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input int value);
    drain();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CAP_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // push_pct steers the stacks toward full or toward empty
  task automatic random_items(input int count, input int push_pct);
    logic [CMD_W-1:0] cmd;
    logic [SEL_W-1:0] sel;
    int               roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 3)             cmd = CMD_NONE;
      else if (roll < push_pct) cmd = CMD_PUSH;
      else                      cmd = ($urandom_range(2) == 0) ? CMD_TOP : CMD_POP;
      sel = ($urandom_range(19) == 0) ? SEL_NONE : SEL_W'($urandom_range(NUM_STACKS - 1));
      send_item(cmd, sel, pick_value());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill, overflow and underflow a small stack; touch the other stacks
    write_capacity(2);
    send_item(CMD_PUSH, 2'd0, 32'sh7fffffff);
    send_item(CMD_PUSH, 2'd0, 32'sh80000000);
    send_item(CMD_PUSH, 2'd0, 32'sh00000001);
    send_item(CMD_TOP,  2'd0, 32'sh0);
    send_item(CMD_POP,  2'd0, 32'sh0);
    send_item(CMD_POP,  2'd0, 32'sh0);
    send_item(CMD_POP,  2'd0, 32'sh0);
    send_item(CMD_TOP,  2'd0, 32'sh0);
    send_item(CMD_PUSH, 2'd1, '1);
    send_item(CMD_PUSH, 2'd2, '0);
    send_item(CMD_NONE, 2'd1, 32'sh0f0f0f0f);
    send_item(CMD_PUSH, SEL_NONE, 32'sh5555aaaa);
    send_item(CMD_POP,  SEL_NONE, 32'sh0);
    send_item(CMD_TOP,  SEL_NONE, 32'sh0);
    send_item(CMD_POP,  2'd1, 32'sh0);
    send_item(CMD_TOP,  2'd2, 32'sh0);
    send_item(CMD_PUSH, 2'd0, 32'shaaaa5555);
    send_item(CMD_PUSH, 2'd0, 32'sh12345678);

    // lower the capacity under the current fill: pushes refused, pops work
    write_capacity(1);
    send_item(CMD_PUSH, 2'd0, 32'sh00000002);
    send_item(CMD_TOP,  2'd0, 32'sh0);
    send_item(CMD_POP,  2'd0, 32'sh0);
    send_item(CMD_POP,  2'd0, 32'sh0);

    // zero capacity acts as one
    write_capacity(0);
    send_item(CMD_PUSH, 2'd0, 32'sh00000003);
    send_item(CMD_PUSH, 2'd0, 32'sh00000004);
    send_item(CMD_POP,  2'd0, 32'sh0);

    foreach (cap_plan[p]) begin
      write_capacity(cap_plan[p]);
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 67; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      if (p == 0) begin
        // hold the result side while items keep coming, so the block backs up
        hold_request = 1'b1;
        random_items(40, 60);
      end
      for (int c = 0; c < 4; c++) random_items(48, (c % 2 == 0) ? 85 : 20);
    end

    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
